@@ rtl/clipped_uv_sphere_tessellator_assert.svh @@
// Assertion macros for the sphere tessellator
`ifndef CLIPPED_UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define CLIPPED_UV_SPHERE_TESSELLATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CUST_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tessellator check failed");

// next-cycle implication, checked out of reset
`define CUST_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tessellator check failed");

`endif

@@ rtl/cust_pkg.sv @@
// Shared types and constants of the sphere tessellator
package cust_pkg;

    localparam int NUM_W = 41;

    localparam logic [1:0] CFG_STACK_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SLICE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TOP_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_BOTTOM_LIMIT = 2'd3;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam logic [7:0] DIV_SIN [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [7:0] DIV_COS [7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

    localparam logic [31:0] RECIP_SIN [7] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210)};
    localparam logic [31:0] RECIP_COS [7] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182)};

    typedef struct packed {
        logic [8:0]         stack_count;
        logic [8:0]         slice_count;
        logic signed [15:0] top_limit;
        logic signed [15:0] bottom_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] z0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] z1;
        logic [17:0]        base;
        logic               tris;
    } t_job;

    typedef enum logic [3:0] {
        F_IDLE, F_CHECK, F_DIV_TOP, F_TRIG_TOP, F_DIV_BOT, F_TRIG_BOT,
        F_CLIP, F_DIV_STEP, F_TRIG_STEP, F_MUL, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        T_IDLE, T_X, T_X2, T_MP, T_MR, T_FIX, T_MAP, T_DONE
    } t_trig_state;

endpackage

@@ rtl/cust_div.sv @@
// Restoring divider, one quotient bit per cycle
module cust_div import cust_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [8:0]       i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [8:0]       r_rem;
    logic [8:0]       r_den;
    logic [9:0]       rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == CNT_W'(NUM_W - 1));
    assign o_quot = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end else begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? 9'(rem_sh - {1'b0, r_den}) : rem_sh[8:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

endmodule

@@ rtl/cust_trig.sv @@
// Sine and cosine by series, one shared multiplier stepped over the terms
module cust_trig import cust_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_phase,
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    localparam logic signed [33:0] ONE = 34'sd1073741824;

    t_trig_state r_state, n_state;

    logic [1:0]         r_quad;
    logic [29:0]        r_r;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [31:0]        r_ts;
    logic [31:0]        r_tc;
    logic signed [33:0] r_sn;
    logic signed [33:0] r_cs;
    logic [31:0]        r_p;
    logic [31:0]        r_q0;
    logic [2:0]         r_k;
    logic               r_sel;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [2:0]         tidx;
    logic [7:0]         tdiv;
    logic [39:0]        rem;
    logic [31:0]        term;
    logic signed [33:0] s_map;
    logic signed [33:0] c_map;

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        if (v > ONE) begin
            return 32'sd1073741824;
        end else if (v < -ONE) begin
            return -32'sd1073741824;
        end
        return 32'(v);
    endfunction

    assign tidx = 3'(r_k - 3'd1);
    assign tdiv = r_sel ? DIV_COS[tidx] : DIV_SIN[tidx];
    assign prod = 64'(mul_a) * 64'(mul_b);
    assign rem  = {8'd0, r_p} - (40'(r_q0) * 40'(tdiv));
    assign term = r_q0 + 32'(rem >= 40'(tdiv));

    always_comb begin
        case (r_state)
            T_X:     begin mul_a = {2'b0, r_r};  mul_b = HALF_PI_Q30; end
            T_X2:    begin mul_a = {1'b0, r_x};  mul_b = {1'b0, r_x}; end
            T_MP:    begin mul_a = r_sel ? r_tc : r_ts; mul_b = r_x2; end
            T_MR:    begin
                mul_a = r_p;
                mul_b = r_sel ? RECIP_COS[tidx] : RECIP_SIN[tidx];
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        case (r_quad)
            2'd0:    begin s_map = r_sn;  c_map = r_cs;  end
            2'd1:    begin s_map = r_cs;  c_map = -r_sn; end
            2'd2:    begin s_map = -r_sn; c_map = -r_cs; end
            default: begin s_map = -r_cs; c_map = r_sn;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            T_IDLE:  if (i_start) n_state = T_X;
            T_X:     n_state = T_X2;
            T_X2:    n_state = T_MP;
            T_MP:    n_state = T_MR;
            T_MR:    n_state = T_FIX;
            T_FIX:   n_state = (r_sel && r_k == 3'd7) ? T_MAP : T_MP;
            T_MAP:   n_state = T_DONE;
            T_DONE:  begin
                o_done  = 1'b1;
                n_state = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                r_quad <= i_phase[31:30];
                r_r    <= i_phase[29:0];
            end
            T_X:  r_x <= prod[60:30];
            T_X2: begin
                r_x2  <= prod[61:30];
                r_ts  <= {1'b0, r_x};
                r_tc  <= 32'd1073741824;
                r_sn  <= 34'(r_x);
                r_cs  <= ONE;
                r_k   <= 3'd1;
                r_sel <= 1'b0;
            end
            T_MP: r_p  <= prod[61:30];
            T_MR: r_q0 <= prod[63:32];
            T_FIX: begin
                if (r_sel) begin
                    r_tc <= term;
                    r_cs <= r_k[0] ? r_cs - 34'(term) : r_cs + 34'(term);
                    r_k  <= r_k + 3'd1;
                end else begin
                    r_ts <= term;
                    r_sn <= r_k[0] ? r_sn - 34'(term) : r_sn + 34'(term);
                end
                r_sel <= !r_sel;
            end
            T_MAP: begin
                r_sin <= clamp_unit(s_map);
                r_cos <= clamp_unit(c_map);
            end
            default: ;
        endcase
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ rtl/cust_front.sv @@
// Front end: accept, range check, angles, clipping, vertex positions and indices
module cust_front import cust_pkg::*; #(
    parameter int MAX_DIVISIONS   = 256,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stack_index,
    input  logic [8:0]  i_slice_index,
    output logic        o_push,
    input  logic        i_full,
    output t_job        o_job
);
    localparam int          SH   = 30 - COORD_FRAC_BITS;
    localparam logic [31:0] HALF = (32'd1 << SH) >> 1;

    t_front_state r_state, n_state;

    logic [7:0]         r_si;
    logic [8:0]         r_sj;
    logic [8:0]         r_stacks;
    logic [8:0]         r_slices;
    logic signed [31:0] r_s0;
    logic signed [31:0] r_s1;
    logic signed [31:0] r_sm;
    logic signed [31:0] r_cm;
    logic signed [31:0] r_zt;
    logic signed [31:0] r_zb;
    logic [2:0]         r_mcnt;
    logic [61:0]        r_prod;
    logic               r_pneg;
    logic signed [15:0] r_x0;
    logic signed [15:0] r_y0;
    logic signed [15:0] r_x1;
    logic signed [15:0] r_y1;
    logic [17:0]        r_vcount;
    logic [17:0]        r_bbase;

    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_num;
    logic [8:0]         div_den;
    logic [31:0]        div_quot;
    logic               trig_start;
    logic               trig_done;
    logic signed [31:0] trig_sin;
    logic signed [31:0] trig_cos;
    logic               accept;
    logic signed [31:0] top_ext;
    logic signed [31:0] bot_ext;
    logic signed [31:0] mop_a;
    logic signed [31:0] mop_b;
    logic [30:0]        mag_a;
    logic [30:0]        mag_b;
    logic [30:0]        pq30;
    logic [31:0]        pfrac;
    logic signed [15:0] pval;
    logic [17:0]        base_now;
    logic [17:0]        vbase;

    function automatic logic [8:0] clamp_count(input logic [8:0] v);
        if (v == 9'd0) begin
            return 9'd1;
        end else if (32'(v) > MAX_DIVISIONS) begin
            return 9'(MAX_DIVISIONS);
        end
        return v;
    endfunction

    function automatic logic signed [31:0] to_frac(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [31:0] rnd;
        mag = v[31] ? 32'(-v) : 32'(v);
        rnd = (mag + HALF) >> SH;
        return v[31] ? -$signed(rnd) : $signed(rnd);
    endfunction

    cust_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cust_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_phase (div_quot),
        .o_done  (trig_done),
        .o_sin   (trig_sin),
        .o_cos   (trig_cos)
    );

    assign o_ready    = (r_state == F_IDLE);
    assign accept     = i_valid && o_ready;
    assign div_start  = (r_state == F_DIV_TOP) || (r_state == F_DIV_BOT) ||
                        (r_state == F_DIV_STEP);
    assign trig_start = (r_state == F_TRIG_TOP) || (r_state == F_TRIG_BOT) ||
                        (r_state == F_TRIG_STEP);
    assign top_ext    = 32'(i_cfg.top_limit);
    assign bot_ext    = 32'(i_cfg.bottom_limit);

    always_comb begin
        case (r_state)
            F_DIV_TOP: begin
                div_num = {2'b0, r_si, 31'd0};
                div_den = r_stacks;
            end
            F_DIV_BOT: begin
                div_num = {1'b0, 9'({1'b0, r_si} + 9'd1), 31'd0};
                div_den = r_stacks;
            end
            default: begin
                div_num = {r_sj, 32'd0};
                div_den = r_slices;
            end
        endcase
    end

    always_comb begin
        case (r_mcnt[2:1])
            2'd0:    begin mop_a = r_cm; mop_b = r_s0; end
            2'd1:    begin mop_a = r_sm; mop_b = r_s0; end
            2'd2:    begin mop_a = r_cm; mop_b = r_s1; end
            default: begin mop_a = r_sm; mop_b = r_s1; end
        endcase
    end

    assign mag_a = mop_a[31] ? 31'(-mop_a) : 31'(mop_a);
    assign mag_b = mop_b[31] ? 31'(-mop_b) : 31'(mop_b);
    assign pq30  = 31'((r_prod + (62'd1 << 29)) >> 30);
    assign pfrac = (32'(pq30) + HALF) >> SH;
    assign pval  = r_pneg ? 16'(-pfrac) : 16'(pfrac);

    assign vbase    = (r_sj == 9'd0) ? r_vcount : r_bbase;
    assign base_now = 18'(vbase + 18'({r_sj, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE:      if (accept) n_state = F_CHECK;
            F_CHECK: begin
                if ({1'b0, r_si} >= r_stacks || r_sj > r_slices) begin
                    n_state = F_IDLE;
                end else begin
                    n_state = F_DIV_TOP;
                end
            end
            F_DIV_TOP:   if (div_done) n_state = F_TRIG_TOP;
            F_TRIG_TOP:  if (trig_done) n_state = F_DIV_BOT;
            F_DIV_BOT:   if (div_done) n_state = F_TRIG_BOT;
            F_TRIG_BOT:  if (trig_done) n_state = F_CLIP;
            F_CLIP: begin
                if (r_zt > top_ext || r_zb < bot_ext) begin
                    n_state = F_IDLE;
                end else begin
                    n_state = F_DIV_STEP;
                end
            end
            F_DIV_STEP:  if (div_done) n_state = F_TRIG_STEP;
            F_TRIG_STEP: if (trig_done) n_state = F_MUL;
            F_MUL:       if (r_mcnt == 3'd7) n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default:     n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_bbase  <= '0;
        end else if (o_push) begin
            r_vcount <= r_vcount + 18'd2;
            r_bbase  <= vbase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_si     <= i_stack_index;
            r_sj     <= i_slice_index;
            r_stacks <= clamp_count(i_cfg.stack_count);
            r_slices <= clamp_count(i_cfg.slice_count);
        end
        if (trig_done) begin
            case (r_state)
                F_TRIG_TOP: begin
                    r_s0 <= trig_sin;
                    r_zt <= to_frac(trig_cos);
                end
                F_TRIG_BOT: begin
                    r_s1 <= trig_sin;
                    r_zb <= to_frac(trig_cos);
                end
                default: begin
                    r_sm <= trig_sin;
                    r_cm <= trig_cos;
                end
            endcase
        end
        if (r_state == F_MUL) begin
            r_mcnt <= r_mcnt + 3'd1;
        end else begin
            r_mcnt <= '0;
        end
        if (r_state == F_MUL && !r_mcnt[0]) begin
            r_prod <= 62'(mag_a) * 62'(mag_b);
            r_pneg <= mop_a[31] ^ mop_b[31];
        end
        if (r_state == F_MUL && r_mcnt[0]) begin
            case (r_mcnt[2:1])
                2'd0:    r_x0 <= pval;
                2'd1:    r_y0 <= pval;
                2'd2:    r_x1 <= pval;
                default: r_y1 <= pval;
            endcase
        end
    end

    assign o_job.x0   = r_x0;
    assign o_job.y0   = r_y0;
    assign o_job.z0   = 16'(r_zt);
    assign o_job.x1   = r_x1;
    assign o_job.y1   = r_y1;
    assign o_job.z1   = 16'(r_zb);
    assign o_job.base = base_now;
    assign o_job.tris = (r_sj < r_slices);

endmodule

@@ rtl/cust_fifo.sv @@
// Two-entry queue between front and back end
module cust_fifo import cust_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= 2'(r_cnt + 2'(i_push) - 2'(i_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ rtl/cust_back.sv @@
// Back end: expand a queued job into vertex and triangle records
module cust_back import cust_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_nempty,
    input  t_job         i_job,
    output logic         o_pop,
    output logic         o_tvalid,
    input  logic         i_tready,
    output logic [103:0] o_tdata,
    output logic         o_tuser,
    output logic         o_tlast
);
    logic               r_tvalid;
    logic [1:0]         r_rec;
    logic               r_kind;
    logic               r_last;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic signed [15:0] r_pz;
    logic [17:0]        r_ca;
    logic [17:0]        r_cb;
    logic [17:0]        r_cc;

    logic load;
    logic last_rec;

    assign load     = i_nempty && (!r_tvalid || i_tready);
    assign last_rec = (r_rec == 2'd1 && !i_job.tris) || (r_rec == 2'd3);
    assign o_pop    = load && last_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_rec    <= '0;
        end else if (load) begin
            r_tvalid <= 1'b1;
            r_rec    <= last_rec ? 2'd0 : r_rec + 2'd1;
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= last_rec;
            case (r_rec)
                2'd0: begin
                    r_kind <= KIND_VERTEX;
                    r_px <= i_job.x0; r_py <= i_job.y0; r_pz <= i_job.z0;
                    r_ca <= '0; r_cb <= '0; r_cc <= '0;
                end
                2'd1: begin
                    r_kind <= KIND_VERTEX;
                    r_px <= i_job.x1; r_py <= i_job.y1; r_pz <= i_job.z1;
                    r_ca <= '0; r_cb <= '0; r_cc <= '0;
                end
                2'd2: begin
                    r_kind <= KIND_TRIANGLE;
                    r_px <= '0; r_py <= '0; r_pz <= '0;
                    r_ca <= i_job.base;
                    r_cb <= i_job.base + 18'd1;
                    r_cc <= i_job.base + 18'd2;
                end
                default: begin
                    r_kind <= KIND_TRIANGLE;
                    r_px <= '0; r_py <= '0; r_pz <= '0;
                    r_ca <= i_job.base + 18'd1;
                    r_cb <= i_job.base + 18'd3;
                    r_cc <= i_job.base + 18'd2;
                end
            endcase
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = {2'b00, r_cc, r_cb, r_ca, r_pz, r_py, r_px};
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

endmodule

@@ rtl/clipped_uv_sphere_tessellator.sv @@
// The front end holds one item at a time and accepts the next only once back in idle;
// a kept item needs three divisions and three series evaluations, a clipped one two,
// and an item out of range is dropped at the range check. Records leave at one per
// cycle while the output is ready, through a two-entry queue and an output register.
// Reset: synchronous, active low; clears counters and control, loads register defaults.
module clipped_uv_sphere_tessellator
    import cust_pkg::*;
#(
    parameter int MAX_DIVISIONS   = 256,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,  // stack_index, slice_index
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,  // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    output logic         o_m_axis_tuser,  // kind
    output logic         o_m_axis_tlast
);
    `include "clipped_uv_sphere_tessellator_assert.svh"

    t_cfg r_cfg;
    t_job front_job;
    t_job back_job;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_nempty;
    logic s_accept;
    logic out_tri;
    logic out_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stack_count  <= 9'd32;
            r_cfg.slice_count  <= 9'd32;
            r_cfg.top_limit    <= 16'sd16384;
            r_cfg.bottom_limit <= -16'sd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STACK_COUNT:  r_cfg.stack_count  <= i_cfg_wdata[8:0];
                CFG_SLICE_COUNT:  r_cfg.slice_count  <= i_cfg_wdata[8:0];
                CFG_TOP_LIMIT:    r_cfg.top_limit    <= i_cfg_wdata;
                CFG_BOTTOM_LIMIT: r_cfg.bottom_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    cust_front #(
        .MAX_DIVISIONS   (MAX_DIVISIONS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_stack_index (i_s_axis_tdata[7:0]),
        .i_slice_index (i_s_axis_tdata[16:8]),
        .o_push        (q_push),
        .i_full        (q_full),
        .o_job         (front_job)
    );

    cust_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (front_job),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_nempty (q_nempty),
        .o_job    (back_job)
    );

    cust_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nempty (q_nempty),
        .i_job    (back_job),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_tri  = o_m_axis_tvalid && (o_m_axis_tuser == KIND_TRIANGLE);
    assign out_vtx  = o_m_axis_tvalid && (o_m_axis_tuser == KIND_VERTEX);

    `CUST_ASSERT_IMP(a_tri_no_pos, i_clk, i_rst_n, out_tri, o_m_axis_tdata[47:0] == 48'd0)
    `CUST_ASSERT_IMP(a_vtx_no_idx, i_clk, i_rst_n, out_vtx, o_m_axis_tdata[103:48] == 56'd0)
    `CUST_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_accept, !o_s_axis_tready)
    `CUST_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, q_pop, q_nempty)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the clipped UV-sphere tessellator
module testbench;
    import cust_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  SETTLE       = 320;
    localparam int  TARGET_ITEMS = 280;
    localparam longint ONE30     = 64'sd1073741824;

    typedef struct {
        logic        kind;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [17:0] ca;
        logic [17:0] cb;
        logic [17:0] cc;
        logic        last;
    } t_record;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = CFG_STACK_COUNT;
    logic [15:0]   i_cfg_wdata = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [23:0]   s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [103:0]  m_data;
    logic          m_user;
    logic          m_last;

    // register and state copies for the predictor
    logic [8:0]         stacks_reg;
    logic [8:0]         slices_reg;
    logic signed [15:0] top_reg;
    logic signed [15:0] bot_reg;
    logic [17:0]        vtx_count;
    logic [17:0]        band_start;

    t_record pending_records[$];
    int      errors = 0;
    int      kept_items = 0;
    int      sent_items = 0;
    int      records_seen = 0;
    int      phases_run = 0;
    int      hold_cnt = 0;
    int      stall_cnt = 0;
    int      cycles = 0;
    bit      calm = 1'b0;

    clipped_uv_sphere_tessellator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // stack_index, slice_index
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
        .o_m_axis_tuser  (m_user),   // kind
        .o_m_axis_tlast  (m_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint round_to_frac(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint mul_unit(longint a, longint b);
        longint ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = (ma * mb + (64'sd1 << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE30) return ONE30;
        if (v < -ONE30) return -ONE30;
        return v;
    endfunction

    function automatic void sine_cosine(input logic [31:0] phase,
                                        output longint s, output longint c);
        logic [63:0] r, x, x2, ts, tc;
        longint sn, cs;
        r  = {34'd0, phase[29:0]};
        x  = (r * 64'(HALF_PI_Q30)) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'(ONE30);
        sn = longint'(x);
        cs = ONE30;
        for (int k = 1; k <= 7; k++) begin
            ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                sn -= longint'(ts);
                cs -= longint'(tc);
            end else begin
                sn += longint'(ts);
                cs += longint'(tc);
            end
        end
        case (phase[31:30])
            2'd0: begin s = sn;  c = cs;  end
            2'd1: begin s = cs;  c = -sn; end
            2'd2: begin s = -sn; c = -cs; end
            default: begin s = -cs; c = sn; end
        endcase
        s = clamp_unit(s);
        c = clamp_unit(c);
    endfunction

    function automatic longint clamp_count(logic [8:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return longint'(v);
    endfunction

    function automatic void push_record(logic kind, longint x, longint y, longint z,
                                        logic [17:0] a, logic [17:0] b, logic [17:0] c,
                                        logic last);
        t_record rec;
        rec.kind = kind;
        rec.px = 16'(x);
        rec.py = 16'(y);
        rec.pz = 16'(z);
        rec.ca = a;
        rec.cb = b;
        rec.cc = c;
        rec.last = last;
        pending_records = {pending_records, rec};
    endfunction

    // work out the records caused by one accepted item
    function automatic void predict_item(logic [7:0] si, logic [8:0] sj);
        longint stacks, slices, s0, c0, s1, c1, sm, cm, zt, zb;
        logic [63:0] ph;
        logic [17:0] b;
        logic closing;
        stacks = clamp_count(stacks_reg);
        slices = clamp_count(slices_reg);
        if (longint'(si) >= stacks || longint'(sj) > slices) return;
        ph = (64'(si) << 31) / 64'(stacks);
        sine_cosine(ph[31:0], s0, c0);
        ph = ((64'(si) + 1) << 31) / 64'(stacks);
        sine_cosine(ph[31:0], s1, c1);
        zt = round_to_frac(c0, 16);
        zb = round_to_frac(c1, 16);
        if (zt > longint'(top_reg) || zb < longint'(bot_reg)) return;
        if (sj == 0) band_start = vtx_count;
        ph = (64'(sj) << 32) / 64'(slices);
        sine_cosine(ph[31:0], sm, cm);
        closing = (longint'(sj) == slices);
        push_record(KIND_VERTEX, round_to_frac(mul_unit(cm, s0), 16),
                    round_to_frac(mul_unit(sm, s0), 16), zt, '0, '0, '0, 1'b0);
        push_record(KIND_VERTEX, round_to_frac(mul_unit(cm, s1), 16),
                    round_to_frac(mul_unit(sm, s1), 16), zb, '0, '0, '0, closing);
        b = band_start + 18'(2 * sj);
        if (!closing) begin
            push_record(KIND_TRIANGLE, 0, 0, 0, b, b + 18'd1, b + 18'd2, 1'b0);
            push_record(KIND_TRIANGLE, 0, 0, 0, b + 18'd1, b + 18'd3, b + 18'd2, 1'b1);
        end
        vtx_count = vtx_count + 18'd2;
        kept_items++;
    endfunction

    task automatic send_item(logic [7:0] si, logic [8:0] sj);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, sj, si};
        do @(posedge i_clk); while (!s_ready);
        predict_item(si, sj);
        sent_items++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_STACK_COUNT:  stacks_reg = value[8:0];
            CFG_SLICE_COUNT:  slices_reg = value[8:0];
            CFG_TOP_LIMIT:    top_reg    = value;
            CFG_BOTTOM_LIMIT: bot_reg    = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] st, logic [15:0] sl,
                             logic [15:0] top, logic [15:0] bot);
        drain();
        write_reg(CFG_STACK_COUNT, st);
        write_reg(CFG_SLICE_COUNT, sl);
        write_reg(CFG_TOP_LIMIT, top);
        write_reg(CFG_BOTTOM_LIMIT, bot);
        i_cfg_we <= 1'b0;
        phases_run++;
    endtask

    // whole band, mostly well formed, sometimes broken or noisy
    task automatic send_band(logic [7:0] si);
        longint slices;
        slices = clamp_count(slices_reg);
        for (int j = 0; j <= slices; j++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
            if ($urandom_range(0, 29) == 0) continue;
            send_item(si, 9'(j));
        end
    endtask

    task automatic test_directed();
        send_item(8'd0, 9'd0);
        send_item(8'd0, 9'd1);
        send_item(8'd0, 9'd31);
        send_item(8'd0, 9'd32);
        send_item(8'd0, 9'd33);
        send_item(8'd31, 9'd0);
        send_item(8'd31, 9'd32);
        send_item(8'd32, 9'd0);
        send_item(8'd255, 9'd511);
        send_item(8'd16, 9'd256);
        send_item(8'd15, 9'd16);
        send_item(8'd16, 9'd8);
        configure(16'd256, 16'd256, 16'h7FFF, 16'h8000);
        send_item(8'd255, 9'd0);
        send_item(8'd255, 9'd256);
        send_item(8'd0, 9'd255);
        send_item(8'd128, 9'd128);
        configure(16'h0200, 16'd0, 16'd16384, -16'sd16384);
        send_item(8'd0, 9'd0);
        send_item(8'd0, 9'd1);
        send_item(8'd1, 9'd0);
        configure(16'd16, 16'd4, 16'd8000, -16'sd8000);
        send_item(8'd0, 9'd0);
        send_item(8'd15, 9'd0);
        send_item(8'd5, 9'd2);
        configure(16'd10, 16'd300, -16'sd16384, 16'd16384);
        send_item(8'd3, 9'd0);
        send_item(8'd9, 9'd256);
    endtask

    task automatic test_random_bands();
        while (sent_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 5))
                0: configure(16'd1, 16'd1, 16'd16384, -16'sd16384);
                1: configure(16'd256, 16'd3, 16'h7FFF, 16'h8000);
                default: configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 8)),
                                   16'($urandom_range(0, 32768) - 16384),
                                   16'($urandom_range(0, 32768) - 16384));
            endcase
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) begin
                send_band(8'($urandom_range(0, clamp_count(stacks_reg) - 1)));
                if (stacks_reg == 256 && $urandom_range(0, 1) == 1) send_band(8'd255);
            end
            calm = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        configure(16'd8, 16'd6, 16'd16384, -16'sd16384);
        hold_cnt = 3000;
        calm = 1'b1;
        for (int j = 0; j <= 6; j++) begin
            send_item(8'd3, 9'(j));
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_record exp_rec;
        if (m_valid && m_ready) begin
            records_seen++;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record tdata=%h tuser=%b tlast=%b",
                         $time, m_data, m_user, m_last);
                errors++;
            end else begin
                exp_rec = pending_records.pop_front();
                if (m_user !== exp_rec.kind || m_data[15:0] !== exp_rec.px
                        || m_data[31:16] !== exp_rec.py || m_data[47:32] !== exp_rec.pz
                        || m_data[65:48] !== exp_rec.ca || m_data[83:66] !== exp_rec.cb
                        || m_data[101:84] !== exp_rec.cc || m_last !== exp_rec.last) begin
                    $display({"%0t: mismatch expected kind=%b x=%h y=%h z=%h",
                              " a=%h b=%h c=%h last=%b"},
                             $time, exp_rec.kind, exp_rec.px, exp_rec.py, exp_rec.pz,
                             exp_rec.ca, exp_rec.cb, exp_rec.cc, exp_rec.last);
                    $display({"%0t:          actual   kind=%b x=%h y=%h z=%h",
                              " a=%h b=%h c=%h last=%b"},
                             $time, m_user, m_data[15:0], m_data[31:16], m_data[47:32],
                             m_data[65:48], m_data[83:66], m_data[101:84], m_last);
                    errors++;
                end
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (calm || !i_rst_n) begin
            m_ready <= i_rst_n;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3) stall_cnt = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        stacks_reg = 9'd32;
        slices_reg = 9'd32;
        top_reg    = 16'sd16384;
        bot_reg    = -16'sd16384;
        vtx_count  = '0;
        band_start = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_bands();
        drain();
        $display("Covered %0d items (%0d kept) in %0d register settings, %0d records checked.",
                 sent_items, kept_items, phases_run, records_seen);
        $display("Included clipping, closing steps, clamped counts and a long output hold-off.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
